// ===== hdl/smdu_pkg.sv =====
// ---------------------------------------------------------------------------
// smdu_pkg
// Shared types and constants for the serial multiply/divide unit.
// ---------------------------------------------------------------------------
package smdu_pkg;

    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned SHIFT_W   = 24;
    localparam int unsigned MUL_CNT_W = 4;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [MUL_CNT_W-1:0] MUL_STEPS = MUL_CNT_W'(8);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(16);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 2'd0,
        OP_START_MUL = 2'd1,
        OP_START_DIV = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [MUL_CNT_W-1:0] mul_steps_left;
        logic [DIV_CNT_W-1:0] div_steps_left;
        logic [WORD_W-1:0]    quotient;
        logic [WORD_W-1:0]    accum;
        logic [SHIFT_W-1:0]   shift;
    } smdu_state_t;

endpackage

// ===== hdl/smdu_step.sv =====
// ---------------------------------------------------------------------------
// smdu_step
// Next-state logic: applies one word (tick or start) to the unit state.
// ---------------------------------------------------------------------------
module smdu_step (
    input  smdu_pkg::smdu_state_t        cur,
    input  logic [smdu_pkg::OPCODE_W-1:0] opcode,
    input  logic [smdu_pkg::BYTE_W-1:0]   multiplicand,
    input  logic [smdu_pkg::BYTE_W-1:0]   factor_or_divisor,
    input  logic [smdu_pkg::WORD_W-1:0]   dividend,
    output smdu_pkg::smdu_state_t        nxt,
    output logic                          busy
);
    import smdu_pkg::*;

    smdu_state_t        mul_st;
    smdu_state_t        div_st;
    logic [SHIFT_W-1:0] half_shift;
    logic               cur_busy;
    logic               take_sub;

    assign cur_busy = (cur.mul_steps_left != '0) || (cur.div_steps_left != '0);

    // multiply step
    always_comb
    begin
        mul_st = cur;
        if (cur.mul_steps_left != '0)
        begin
            mul_st.mul_steps_left = cur.mul_steps_left - MUL_CNT_W'(1);
            if (cur.quotient[0])
            begin
                mul_st.accum = cur.accum + cur.shift[WORD_W-1:0];
            end
            mul_st.quotient = {1'b0, cur.quotient[WORD_W-1:1]};
            mul_st.shift    = {cur.shift[SHIFT_W-2:0], 1'b0};
        end
    end

    // divide step, after the multiply step
    assign half_shift = {1'b0, mul_st.shift[SHIFT_W-1:1]};
    assign take_sub   = {{(SHIFT_W-WORD_W){1'b0}}, mul_st.accum} >= half_shift;

    always_comb
    begin
        div_st = mul_st;
        if (mul_st.div_steps_left != '0)
        begin
            div_st.div_steps_left = mul_st.div_steps_left - DIV_CNT_W'(1);
            div_st.shift          = half_shift;
            div_st.quotient       = {mul_st.quotient[WORD_W-2:0], take_sub};
            if (take_sub)
            begin
                div_st.accum = mul_st.accum - half_shift[WORD_W-1:0];
            end
        end
    end

    always_comb
    begin
        nxt = cur;
        case (opcode)
            OP_TICK:
            begin
                nxt = div_st;
            end
            OP_START_MUL:
            begin
                if (!cur_busy)
                begin
                    nxt.quotient       = {{(WORD_W-BYTE_W){1'b0}}, multiplicand};
                    nxt.accum          = '0;
                    nxt.shift          = {{(SHIFT_W-BYTE_W){1'b0}}, factor_or_divisor};
                    nxt.mul_steps_left = MUL_STEPS;
                end
            end
            OP_START_DIV:
            begin
                if (!cur_busy)
                begin
                    nxt.accum          = dividend;
                    nxt.shift          = {factor_or_divisor, {(SHIFT_W-BYTE_W){1'b0}}};
                    nxt.div_steps_left = DIV_STEPS;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign busy = (nxt.mul_steps_left != '0) || (nxt.div_steps_left != '0);

endmodule

// ===== hdl/serial_multiply_divide_unit.sv =====
// ---------------------------------------------------------------------------
// serial_multiply_divide_unit
// Bit-serial 8x8 multiply and 16/8 restoring divide, one step per tick word.
// A result is registered and becomes valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; in_ready stays high while the result
// register is empty or being taken, so stalls come only from out_ready.
// Reset (rst_n, async, active low) clears the unit state and the result
// valid flag.
// ---------------------------------------------------------------------------
module serial_multiply_divide_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [smdu_pkg::OPCODE_W-1:0]   opcode,
    input  logic [smdu_pkg::BYTE_W-1:0]     multiplicand,
    input  logic [smdu_pkg::BYTE_W-1:0]     factor_or_divisor,
    input  logic [smdu_pkg::WORD_W-1:0]     dividend,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [smdu_pkg::WORD_W-1:0]     quotient_out,
    output logic [smdu_pkg::WORD_W-1:0]     product_or_remainder,
    output logic                            busy_res
);
    import smdu_pkg::*;

    smdu_state_t       state_reg;
    smdu_state_t       state_next;
    logic              busy_next;
    logic              out_valid_reg;
    logic [WORD_W-1:0] quotient_out_reg;
    logic [WORD_W-1:0] product_reg;
    logic              busy_reg;
    logic              in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    smdu_step u_step (
        .cur               (state_reg),
        .opcode            (opcode),
        .multiplicand      (multiplicand),
        .factor_or_divisor (factor_or_divisor),
        .dividend          (dividend),
        .nxt               (state_next),
        .busy              (busy_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            quotient_out_reg <= state_next.quotient;
            product_reg      <= state_next.accum;
            busy_reg         <= busy_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign quotient_out         = quotient_out_reg;
    assign product_or_remainder = product_reg;
    assign busy_res             = busy_reg;

endmodule

// ===== hdl/smdu_checker.sv =====
// ---------------------------------------------------------------------------
// smdu_checker
// Port-level checks for the serial multiply/divide unit, bound to the top.
// ---------------------------------------------------------------------------
module smdu_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [smdu_pkg::OPCODE_W-1:0]   opcode,
    input  logic [smdu_pkg::BYTE_W-1:0]     multiplicand,
    input  logic [smdu_pkg::BYTE_W-1:0]     factor_or_divisor,
    input  logic [smdu_pkg::WORD_W-1:0]     dividend,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [smdu_pkg::WORD_W-1:0]     quotient_out,
    input  logic [smdu_pkg::WORD_W-1:0]     product_or_remainder,
    input  logic                            busy_res
);
    import smdu_pkg::*;

    logic last_busy_reg;
    logic prev_busy;
    logic start_mul_idle;

    // track busy of the last result delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_busy_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            last_busy_reg <= busy_res;
        end
    end

    assign prev_busy      = out_valid ? busy_res : last_busy_reg;
    assign start_mul_idle = in_valid && in_ready && !prev_busy &&
                            (opcode == OP_START_MUL);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quotient_out) &&
        $stable(product_or_remainder) && $stable(busy_res))
        else $error("stalled result changed");

    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_mul_idle |=> busy_res && (product_or_remainder == '0) &&
        (quotient_out == {{(WORD_W-BYTE_W){1'b0}}, $past(multiplicand)}))
        else $error("multiply start loaded wrong state");

endmodule

bind serial_multiply_divide_unit smdu_checker u_smdu_checker (.*);
